@@ hdl/edist_pkg.sv @@
// shared constants, action codes and helpers for the edit distance engine
package edist_pkg;

  // default sizing of the string stores
  localparam int MaxLenDefault     = 64;
  localparam int SymbolBitsDefault = 8;

  // port field widths
  localparam int ActionBits = 2;
  localparam int SymbolIn   = 8;
  localparam int DistBits   = 7;
  localparam int DistMax    = (1 << DistBits) - 1;

  // action codes
  localparam logic [ActionBits-1:0] ActFirst   = 2'd0;
  localparam logic [ActionBits-1:0] ActSecond  = 2'd1;
  localparam logic [ActionBits-1:0] ActCompute = 2'd2;

  // clamp a distance to the output field
  function automatic logic [DistBits-1:0] sat_dist(input int unsigned val);
    logic [DistBits-1:0] res;
    if (val > DistMax) begin
      res = DistBits'(DistMax);
    end else begin
      res = DistBits'(val);
    end
    return res;
  endfunction

endpackage

@@ hdl/edist_ram.sv @@
// generic single write port, single read port ram with registered read
module edist_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds its data while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/edit_distance_engine_unit.sv @@
// edit distance engine top level: string loading, row sweep and result strobe
//
// Append items (action 0 or 1) never raise busy_o. A compute
// item (action 2) sweeps the cost table one cell per cycle over one stored
// cost row, with a read setup state before the cells of each row, as the
// cost row memory has a single registered read port. busy_o stays high for
// the whole sweep, and valid_o pulses in the same cycle that busy_o falls.
// When either string is empty the result pulses in the next cycle and
// busy_o stays low. The result is on distance_o and overflowed_o, marked by
// valid_o for a single cycle; the receiver must take it then, as there is
// no way to hold it off.
// After the result both strings are empty and the overflow flag is clear.
module edit_distance_engine_unit
  import edist_pkg::*;
#(
  parameter int MAX_LEN     = MaxLenDefault,
  parameter int SYMBOL_BITS = SymbolBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [ActionBits-1:0] action_i,
  input  logic [SymbolIn-1:0]   symbol_i,
  output logic                  valid_o,
  output logic [DistBits-1:0]   distance_o,
  output logic                  overflowed_o
);

  // string address width and length / cost width
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam logic [LW-1:0] FullLen = LW'(MAX_LEN);
  localparam logic [LW-1:0] One     = LW'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CELL
  } state_e;

  state_e                state_q;
  logic [LW-1:0]         len1_q, len2_q;
  logic                  ovf_q;
  logic [LW-1:0]         row_q, col_q;
  logic [LW-1:0]         left_q, diag_q;
  logic                  valid_q;
  logic [DistBits-1:0]   dist_q;
  logic                  ovf_out_q;

  logic                  accept;
  logic [SYMBOL_BITS-1:0] sym;
  logic                  first_we, second_we;
  logic                  first_re, second_re, cost_re;
  logic [AW-1:0]         second_raddr;
  logic [LW-1:0]         cost_raddr;
  logic [LW-1:0]         row_m1;
  logic [SYMBOL_BITS-1:0] first_rd, second_rd;
  logic [LW-1:0]         cost_rd;
  logic [LW-1:0]         above, min_al, min_all, cell_val;
  logic                  cost_we;

  assign accept = start_i && (state_q == ST_IDLE);
  assign sym    = SYMBOL_BITS'(symbol_i);
  assign row_m1 = row_q - One;

  // string writes on append transfers that fit
  assign first_we  = accept && (action_i == ActFirst) && (len1_q != FullLen);
  assign second_we = accept && (action_i == ActSecond) && (len2_q != FullLen);

  // reads: row setup fetches the row symbol and the first column, cells fetch ahead
  assign first_re     = (state_q == ST_SETUP);
  assign second_re    = (state_q == ST_SETUP) || ((state_q == ST_CELL) && (col_q != len2_q));
  assign cost_re      = second_re;
  assign second_raddr = (state_q == ST_SETUP) ? AW'(0) : col_q[AW-1:0];
  assign cost_raddr   = (state_q == ST_SETUP) ? One : col_q + One;

  // cell update: the first row sees the implicit initial row
  always_comb begin
    above    = (row_q == One) ? col_q : cost_rd;
    min_al   = (above < left_q) ? above : left_q;
    min_all  = (min_al < diag_q) ? min_al : diag_q;
    cell_val = (first_rd == second_rd) ? diag_q : min_all + One;
  end

  assign cost_we = (state_q == ST_CELL);

  edist_ram #(
    .Width(SYMBOL_BITS),
    .Depth(MAX_LEN),
    .AddrW(AW)
  ) u_first_ram (
    .clk_i  (clk_i),
    .we_i   (first_we),
    .waddr_i(len1_q[AW-1:0]),
    .wdata_i(sym),
    .re_i   (first_re),
    .raddr_i(row_m1[AW-1:0]),
    .rdata_o(first_rd)
  );

  edist_ram #(
    .Width(SYMBOL_BITS),
    .Depth(MAX_LEN),
    .AddrW(AW)
  ) u_second_ram (
    .clk_i  (clk_i),
    .we_i   (second_we),
    .waddr_i(len2_q[AW-1:0]),
    .wdata_i(sym),
    .re_i   (second_re),
    .raddr_i(second_raddr),
    .rdata_o(second_rd)
  );

  edist_ram #(
    .Width(LW),
    .Depth(MAX_LEN + 1),
    .AddrW(LW)
  ) u_cost_ram (
    .clk_i  (clk_i),
    .we_i   (cost_we),
    .waddr_i(col_q),
    .wdata_i(cell_val),
    .re_i   (cost_re),
    .raddr_i(cost_raddr),
    .rdata_o(cost_rd)
  );

  // control state machine and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len1_q    <= '0;
      len2_q    <= '0;
      ovf_q     <= 1'b0;
      row_q     <= '0;
      col_q     <= '0;
      valid_q   <= 1'b0;
      ovf_out_q <= 1'b0;
      dist_q    <= '0;
      left_q    <= '0;
      diag_q    <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (action_i)
              ActFirst: begin
                if (len1_q == FullLen) begin
                  ovf_q <= 1'b1;
                end else begin
                  len1_q <= len1_q + One;
                end
              end
              ActSecond: begin
                if (len2_q == FullLen) begin
                  ovf_q <= 1'b1;
                end else begin
                  len2_q <= len2_q + One;
                end
              end
              ActCompute: begin
                ovf_out_q <= ovf_q;
                ovf_q     <= 1'b0;
                if ((len1_q == '0) || (len2_q == '0)) begin
                  // one side empty: distance is the other length
                  valid_q <= 1'b1;
                  dist_q  <= sat_dist(32'(len1_q | len2_q));
                  len1_q  <= '0;
                  len2_q  <= '0;
                end else begin
                  row_q   <= One;
                  state_q <= ST_SETUP;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SETUP: begin
          // column zero of this row and of the row above
          col_q   <= One;
          left_q  <= row_q;
          diag_q  <= row_m1;
          state_q <= ST_CELL;
        end
        ST_CELL: begin
          left_q <= cell_val;
          diag_q <= above;
          if (col_q == len2_q) begin
            if (row_q == len1_q) begin
              valid_q <= 1'b1;
              dist_q  <= sat_dist(32'(cell_val));
              len1_q  <= '0;
              len2_q  <= '0;
              state_q <= ST_IDLE;
            end else begin
              row_q   <= row_q + One;
              state_q <= ST_SETUP;
            end
          end else begin
            col_q <= col_q + One;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign valid_o      = valid_q;
  assign distance_o   = dist_q;
  assign overflowed_o = ovf_out_q;

endmodule
